// ===== hdl/gwm_pkg.sv =====
// Shared types and constants for the grid window minimum-fill scanner.
package gwm_pkg;

  localparam int CNT_W       = 7;   // run count, marked count, window length, cost
  localparam int ROW_WIDTH_W = 9;   // row_width register
  localparam int CFG_DATA_W  = 9;   // widest configuration register
  localparam int REG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] COST_NONE = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CELL_EMPTY   = 2'd0,
    CELL_MARKED  = 2'd1,
    CELL_BLOCKED = 2'd2
  } cell_sym_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'd0,
    REG_ROW_WIDTH     = 1'd1
  } cfg_reg_t;

  // Window score of one line scanner for one cell.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] cost;
  } scan_score_t;

endpackage

// ===== hdl/gwm_channels_if.sv =====
// Valid/ready channel interfaces: cell input, result output, configuration write.
interface gwm_cell_if;
  import gwm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cell_req;
  logic       last;
  modport source (output valid, output cell_req, output last, input ready);
  modport sink   (input valid, input cell_req, input last, output ready);
endinterface

interface gwm_result_if;
  import gwm_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [CNT_W-1:0] min_empty;
  modport source (output valid, output found, output min_empty, input ready);
  modport sink   (input valid, input found, input min_empty, output ready);
endinterface

interface gwm_cfg_if;
  import gwm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gwm_line_scan.sv =====
// One-cell update of a line scanner: run count, marked count, marked history and score.
module gwm_line_scan #(
  parameter int HIST_W = 64
) (
  input  logic [1:0]                 sym,
  input  logic [gwm_pkg::CNT_W-1:0]  k,
  input  logic [gwm_pkg::CNT_W-1:0]  run_i,
  input  logic [gwm_pkg::CNT_W-1:0]  marked_i,
  input  logic [HIST_W-1:0]          hist_i,
  output logic [gwm_pkg::CNT_W-1:0]  run_o,
  output logic [gwm_pkg::CNT_W-1:0]  marked_o,
  output logic [HIST_W-1:0]          hist_o,
  output gwm_pkg::scan_score_t       score
);
  import gwm_pkg::*;

  localparam int HIDX_W = (HIST_W > 1) ? $clog2(HIST_W) : 1;

  logic             blocked;
  logic             mk;
  logic             oldest;
  logic [CNT_W-1:0] km1;
  logic [CNT_W:0]   r_ext;
  logic [CNT_W-1:0] m;

  assign km1 = k - CNT_W'(1);

  always_comb begin
    blocked  = !(cell_sym_t'(sym) == CELL_EMPTY || cell_sym_t'(sym) == CELL_MARKED);
    mk       = (cell_sym_t'(sym) == CELL_MARKED);
    oldest   = hist_i[km1[HIDX_W-1:0]];
    r_ext    = {1'b0, run_i} + (CNT_W+1)'(1);
    m        = marked_i + CNT_W'(mk);
    // full window: slide by one, drop the oldest mark
    if (r_ext > {1'b0, k}) begin
      r_ext = {1'b0, k};
      if (oldest && m != '0) begin
        m = m - CNT_W'(1);
      end
    end
    if (blocked) begin
      run_o      = '0;
      marked_o   = '0;
      hist_o     = '0;
      score.hit  = 1'b0;
      score.cost = '0;
    end else begin
      run_o      = r_ext[CNT_W-1:0];
      marked_o   = m;
      hist_o     = (hist_i << 1) | HIST_W'(mk);
      score.hit  = (r_ext == {1'b0, k});
      score.cost = (m >= k) ? '0 : (k - m);
    end
  end

endmodule

// ===== hdl/gwm_col_mem.sv =====
// Column state memory: one write and one registered read per cycle, with write-to-read bypass.
module gwm_col_mem #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 78
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DATA_W-1:0]                      rd_data,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_W-1:0]                      wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] byp_data_r;
  logic              byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // same-entry write and read at one edge: the read sees the old word, so keep the new one
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

// ===== hdl/grid_window_min_fill_scan.sv =====
// Top level: raster cell intake, row scan, column read-modify-write and result register.
//
// Accepts one cell per clock in raster order and scores every window of window_length
// blocker-free cells along rows and columns, keeping the least number of empty cells.
// Each cell passes two stages: on acceptance the column position is resolved and the
// column state word is read from a MAX_WIDTH-deep memory; from the stage 1 registers
// the row and column scanners update, the column word is written back and the best cost
// is folded in. A cell that reads the column just written by the cell before it (row
// width of one) gets the new word through a bypass, so the rate stays one cell per cycle.
// The result for the last cell of a grid is registered as that cell leaves stage 1 and
// sits in an output register; intake stalls only when that register is still full and a
// further last cell needs it. Configuration writes are taken at any time and must come
// while the block idles.
module grid_window_min_fill_scan #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_WINDOW = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  gwm_cell_if.sink     in_ch,
  gwm_result_if.source out_ch,
  gwm_cfg_if.sink      cfg_ch
);
  import gwm_pkg::*;

  localparam int CIDX_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
  localparam int ENTRY_W = 2 * CNT_W + MAX_WINDOW;

  // configuration
  logic [CNT_W-1:0]       window_length_r;
  logic [ROW_WIDTH_W-1:0] row_width_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= CNT_W'(1);
      row_width_r     <= ROW_WIDTH_W'(256);
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_WINDOW_LENGTH: window_length_r <= cfg_ch.data[CNT_W-1:0];
        REG_ROW_WIDTH:     row_width_r     <= cfg_ch.data[ROW_WIDTH_W-1:0];
      endcase
    end
  end

  logic [31:0]       k32;
  logic [31:0]       w32;
  logic [CNT_W-1:0]  k_eff;
  logic [WCNT_W-1:0] w_eff;

  always_comb begin
    if (window_length_r == '0) begin
      k32 = 32'd1;
    end else if (32'(window_length_r) > MAX_WINDOW) begin
      k32 = 32'(MAX_WINDOW);
    end else begin
      k32 = 32'(window_length_r);
    end
    if (row_width_r == '0 || 32'(row_width_r) > MAX_WIDTH) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = 32'(row_width_r);
    end
  end

  assign k_eff = k32[CNT_W-1:0];
  assign w_eff = w32[WCNT_W-1:0];

  // stage 0: column position and memory read
  logic              in_ready;
  logic              in_fire;
  logic              s1_fire;
  logic [CIDX_W-1:0] column_index_r, column_index_nxt;
  logic              in_first_row_r, in_first_row_nxt;
  logic [CIDX_W-1:0] cur_col;
  logic              cur_first;
  logic [WCNT_W-1:0] col_plus1;

  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    cur_col   = column_index_r;
    cur_first = in_first_row_r;
    // width shrunk under a partly scanned row: restart at column zero
    if (WCNT_W'(column_index_r) >= w_eff) begin
      cur_col   = '0;
      cur_first = 1'b0;
    end
    col_plus1 = WCNT_W'(cur_col) + WCNT_W'(1);
    if (col_plus1 >= w_eff) begin
      column_index_nxt = '0;
      in_first_row_nxt = 1'b0;
    end else begin
      column_index_nxt = col_plus1[CIDX_W-1:0];
      in_first_row_nxt = cur_first;
    end
    if (in_ch.last) begin
      column_index_nxt = '0;
      in_first_row_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= '0;
      in_first_row_r <= 1'b1;
    end else if (in_fire) begin
      column_index_r <= column_index_nxt;
      in_first_row_r <= in_first_row_nxt;
    end
  end

  // stage 1 registers
  logic              s1_valid_r;
  logic [1:0]        s1_sym_r;
  logic              s1_last_r;
  logic [CIDX_W-1:0] s1_col_r;
  logic              s1_first_r;
  logic              s1_row_start_r;
  logic              out_valid_r;

  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sym_r       <= in_ch.cell_req;
      s1_last_r      <= in_ch.last;
      s1_col_r       <= cur_col;
      s1_first_r     <= cur_first;
      s1_row_start_r <= (cur_col == '0);
    end
  end

  // column memory
  logic [ENTRY_W-1:0] col_rd_data;
  logic [ENTRY_W-1:0] col_wr_data;

  gwm_col_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (ENTRY_W)
  ) u_col_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (cur_col),
    .rd_data (col_rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (col_wr_data)
  );

  // stage 1: row and column scans
  logic [CNT_W-1:0]      row_run_r, row_marked_r;
  logic [MAX_WINDOW-1:0] row_history_r;
  logic [CNT_W-1:0]      row_run_in, row_marked_in, row_run_out, row_marked_out;
  logic [MAX_WINDOW-1:0] row_hist_in, row_hist_out;
  logic [CNT_W-1:0]      col_run_in, col_marked_in, col_run_out, col_marked_out;
  logic [MAX_WINDOW-1:0] col_hist_in, col_hist_out;
  scan_score_t           row_score, col_score;

  always_comb begin
    if (s1_row_start_r) begin
      row_run_in    = '0;
      row_marked_in = '0;
      row_hist_in   = '0;
    end else begin
      row_run_in    = row_run_r;
      row_marked_in = row_marked_r;
      row_hist_in   = row_history_r;
    end
    // first row of a grid: column state starts from zero
    if (s1_first_r) begin
      {col_run_in, col_marked_in, col_hist_in} = '0;
    end else begin
      {col_run_in, col_marked_in, col_hist_in} = col_rd_data;
    end
  end

  gwm_line_scan #(.HIST_W(MAX_WINDOW)) u_row_scan (
    .sym      (s1_sym_r),
    .k        (k_eff),
    .run_i    (row_run_in),
    .marked_i (row_marked_in),
    .hist_i   (row_hist_in),
    .run_o    (row_run_out),
    .marked_o (row_marked_out),
    .hist_o   (row_hist_out),
    .score    (row_score)
  );

  gwm_line_scan #(.HIST_W(MAX_WINDOW)) u_col_scan (
    .sym      (s1_sym_r),
    .k        (k_eff),
    .run_i    (col_run_in),
    .marked_i (col_marked_in),
    .hist_i   (col_hist_in),
    .run_o    (col_run_out),
    .marked_o (col_marked_out),
    .hist_o   (col_hist_out),
    .score    (col_score)
  );

  assign col_wr_data = {col_run_out, col_marked_out, col_hist_out};

  // best cost tracking
  logic [CNT_W-1:0] best_cost_r, best_cost_nxt, best_row;
  logic             any_found_r, any_found_nxt;

  always_comb begin
    best_row      = (row_score.hit && row_score.cost < best_cost_r) ? row_score.cost
                                                                    : best_cost_r;
    best_cost_nxt = (col_score.hit && col_score.cost < best_row) ? col_score.cost : best_row;
    any_found_nxt = any_found_r || row_score.hit || col_score.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_run_r     <= '0;
      row_marked_r  <= '0;
      row_history_r <= '0;
      best_cost_r   <= COST_NONE;
      any_found_r   <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        row_run_r     <= '0;
        row_marked_r  <= '0;
        row_history_r <= '0;
        best_cost_r   <= COST_NONE;
        any_found_r   <= 1'b0;
      end else begin
        row_run_r     <= row_run_out;
        row_marked_r  <= row_marked_out;
        row_history_r <= row_hist_out;
        best_cost_r   <= best_cost_nxt;
        any_found_r   <= any_found_nxt;
      end
    end
  end

  // result register
  logic             found_r;
  logic [CNT_W-1:0] min_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      found_r     <= any_found_nxt;
      min_empty_r <= any_found_nxt ? best_cost_nxt : '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = found_r;
  assign out_ch.min_empty = min_empty_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the grid window minimum-fill scanner.
`timescale 1ns / 100ps

import gwm_pkg::*;

// Mirrors the scanner state per accepted cell and checks grid results in order.
class min_fill_tracker;
  localparam int WIDTH_CAP  = 256;
  localparam int WINDOW_CAP = 64;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] min_empty;
  } grid_result_t;

  logic [CNT_W-1:0]       win_reg;
  logic [ROW_WIDTH_W-1:0] width_reg;

  logic [CNT_W-1:0] row_run;
  logic [CNT_W-1:0] row_marked;
  logic [63:0]      row_hist;
  logic [CNT_W-1:0] col_run    [WIDTH_CAP];
  logic [CNT_W-1:0] col_marked [WIDTH_CAP];
  logic [63:0]      col_hist   [WIDTH_CAP];
  logic [7:0]       col_pos;
  logic             first_row;
  logic [CNT_W-1:0] best_cost;
  logic             any_found;

  grid_result_t grid_results_due[$];
  int           mismatch_count;

  function new();
    win_reg   = 7'd1;
    width_reg = 9'd256;
    for (int i = 0; i < WIDTH_CAP; i++) begin
      col_run[i]    = '0;
      col_marked[i] = '0;
      col_hist[i]   = '0;
    end
    mismatch_count = 0;
    clear_grid();
  endfunction

  static function int eff_window(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > WINDOW_CAP) return WINDOW_CAP;
    return int'(v);
  endfunction

  static function int eff_width(logic [ROW_WIDTH_W-1:0] v);
    if (v == 0 || v > WIDTH_CAP) return WIDTH_CAP;
    return int'(v);
  endfunction

  function void clear_grid();
    row_run    = '0;
    row_marked = '0;
    row_hist   = '0;
    col_pos    = '0;
    first_row  = 1'b1;
    best_cost  = COST_NONE;
    any_found  = 1'b0;
  endfunction

  function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WINDOW_LENGTH: win_reg = data[CNT_W-1:0];
      REG_ROW_WIDTH:     width_reg = data[ROW_WIDTH_W-1:0];
      default: ;
    endcase
  endfunction

  // One line (row or column) takes one cell; a full blocker-free window folds into best_cost.
  function void advance_line(ref logic [CNT_W-1:0] run, ref logic [CNT_W-1:0] marked,
                             ref logic [63:0] hist, input logic [1:0] sym, input int k);
    logic             mk;
    logic             oldest;
    int               r;
    logic [CNT_W-1:0] m;
    int               cost;
    if (sym >= CELL_BLOCKED) begin
      run    = '0;
      marked = '0;
      hist   = '0;
      return;
    end
    mk     = (sym == CELL_MARKED);
    oldest = hist[k-1];
    r      = int'(run) + 1;
    m      = marked + mk;
    if (r > k) begin
      r = k;
      if (oldest && m > 0) m = m - 1'b1;
    end
    run    = CNT_W'(r);
    marked = m;
    hist   = {hist[62:0], mk};
    if (r == k) begin
      cost = (int'(m) >= k) ? 0 : k - int'(m);
      if (cost < int'(best_cost)) best_cost = CNT_W'(cost);
      any_found = 1'b1;
    end
  endfunction

  function void note_cell(logic [1:0] sym, logic is_last);
    int               k;
    int               w;
    int               c;
    logic [CNT_W-1:0] cr;
    logic [CNT_W-1:0] cm;
    logic [63:0]      ch;
    grid_result_t     res;
    k = eff_window(win_reg);
    w = eff_width(width_reg);
    // width shrunk under a row in progress: restart at column 0
    if (int'(col_pos) >= w) begin
      col_pos   = '0;
      first_row = 1'b0;
    end
    if (col_pos == 0) begin
      row_run    = '0;
      row_marked = '0;
      row_hist   = '0;
    end
    advance_line(row_run, row_marked, row_hist, sym, k);
    c  = int'(col_pos);
    cr = '0;
    cm = '0;
    ch = '0;
    if (!first_row) begin
      cr = col_run[c];
      cm = col_marked[c];
      ch = col_hist[c];
    end
    advance_line(cr, cm, ch, sym, k);
    col_run[c]    = cr;
    col_marked[c] = cm;
    col_hist[c]   = ch;
    if (c + 1 >= w) begin
      col_pos   = '0;
      first_row = 1'b0;
    end else begin
      col_pos = 8'(c + 1);
    end
    if (is_last) begin
      res.found     = any_found;
      res.min_empty = any_found ? best_cost : '0;
      grid_results_due.push_back(res);
      clear_grid();
    end
  endfunction

  function void flag(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endfunction

  function void check_result(logic found, logic [CNT_W-1:0] min_empty);
    grid_result_t want;
    if (grid_results_due.size() == 0) begin
      flag($sformatf("unexpected result: found=%0d min_empty=%0d", found, min_empty));
      return;
    end
    want = grid_results_due.pop_front();
    if (found !== want.found)
      flag($sformatf("found mismatch: expected %0d, actual %0d", want.found, found));
    if (min_empty !== want.min_empty)
      flag($sformatf("min_empty mismatch: expected %0d, actual %0d",
                     want.min_empty, min_empty));
  endfunction

  function int outstanding();
    return grid_results_due.size();
  endfunction
endclass

module testbench;
  localparam logic [1:0] CELL_SPARE  = 2'd3;   // undefined symbol, scanned as blocked
  localparam int         SETTLE      = 4;      // pipeline depth plus margin
  localparam int         QUIET_LIMIT = 3000;

  logic clk;
  logic rst_n;

  gwm_cell_if   cell_bus ();
  gwm_result_if result_bus ();
  gwm_cfg_if    cfg_bus ();

  grid_window_min_fill_scan dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cell_bus.sink),
    .out_ch (result_bus.source),
    .cfg_ch (cfg_bus.sink)
  );

  min_fill_tracker board;
  int  cells_sent;
  int  stall_left;
  int  quiet_cycles = 0;
  bit  calm_in;
  bit  calm_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [1:0] pick_cell(int block_pct, int mark_pct);
    if ($urandom_range(0, 99) < block_pct)
      return ($urandom_range(0, 3) == 0) ? CELL_SPARE : CELL_BLOCKED;
    return ($urandom_range(0, 99) < mark_pct) ? CELL_MARKED : CELL_EMPTY;
  endfunction

  task automatic send_cell(input logic [1:0] sym, input logic is_last);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_bus.valid    <= 1'b1;
    cell_bus.cell_req <= sym;
    cell_bus.last     <= is_last;
    do @(posedge clk); while (!cell_bus.ready);
    board.note_cell(sym, is_last);
    cells_sent++;
  endtask

  // Drop valid and wait for every pending grid result.
  task automatic hold_until_drained();
    cell_bus.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    hold_until_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    board.set_register(idx, data);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_window_data(int span);
    int               r;
    logic [CNT_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 70)      k = CNT_W'($urandom_range(1, (span < 8) ? ((span < 1) ? 1 : span) : 8));
    else if (r < 78) k = '0;
    else if (r < 88) k = CNT_W'($urandom_range(64, 127));
    else             k = CNT_W'($urandom_range(9, 63));
    // upper data bits fall outside the window register
    return {2'($urandom_range(0, 3)), k};
  endfunction

  task automatic run_grid(input int cells, input int block_pct, input int mark_pct,
                          input int change_at);
    int cur_w;
    for (int i = 0; i < cells; i++) begin
      if (i == change_at) begin
        cur_w = board.eff_width(board.width_reg);
        // shrink only: a wider row would read column entries never written
        if ($urandom_range(0, 1) == 0)
          write_register(REG_ROW_WIDTH, CFG_DATA_W'($urandom_range(1, cur_w)));
        write_register(REG_WINDOW_LENGTH, pick_window_data(8));
      end
      send_cell(pick_cell(block_pct, mark_pct), i == cells - 1);
    end
  endtask

  // Result sink: random stalls, with stretches of steady ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_bus.valid && result_bus.ready)
        board.check_result(result_bus.found, result_bus.min_empty);
      if ($urandom_range(0, 199) == 0) calm_out = !calm_out;
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        stall_left = pick_gap(calm_out);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((cell_bus.valid && cell_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    cells_sent   = 0;
    calm_in      = 1'b0;
    rst_n             <= 1'b0;
    cell_bus.valid    <= 1'b0;
    cell_bus.cell_req <= CELL_EMPTY;
    cell_bus.last     <= 1'b0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_WINDOW_LENGTH;
    cfg_bus.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: one-cell windows, full-width rows; every symbol incl. the spare one
    send_cell(CELL_EMPTY, 1'b0);
    send_cell(CELL_MARKED, 1'b0);
    send_cell(CELL_BLOCKED, 1'b0);
    send_cell(CELL_SPARE, 1'b1);
    // grid with no window at all
    send_cell(CELL_SPARE, 1'b1);

    write_register(REG_WINDOW_LENGTH, 9'h182);
    write_register(REG_ROW_WIDTH, 9'd3);
    send_cell(CELL_MARKED, 1'b0);
    send_cell(CELL_EMPTY, 1'b0);
    send_cell(CELL_MARKED, 1'b0);
    send_cell(CELL_EMPTY, 1'b0);
    // shrink width under a row in progress and lengthen the window mid-grid
    write_register(REG_ROW_WIDTH, 9'd1);
    write_register(REG_WINDOW_LENGTH, 9'd3);
    send_cell(CELL_MARKED, 1'b0);
    send_cell(CELL_MARKED, 1'b0);
    send_cell(CELL_MARKED, 1'b0);
    send_cell(CELL_EMPTY, 1'b1);

    // zero window acts as one; last flag mid-row
    write_register(REG_WINDOW_LENGTH, 9'd0);
    write_register(REG_ROW_WIDTH, 9'd2);
    send_cell(CELL_EMPTY, 1'b0);
    send_cell(CELL_EMPTY, 1'b0);
    send_cell(CELL_EMPTY, 1'b1);

    // out-of-range values clamp to the maximum
    write_register(REG_WINDOW_LENGTH, 9'd127);
    write_register(REG_ROW_WIDTH, 9'd511);
    send_cell(CELL_MARKED, 1'b1);

    while (cells_sent < 500) begin
      logic [CFG_DATA_W-1:0] wdata;
      int                    r;
      int                    w;
      int                    rows;
      int                    cells;
      int                    grid_count;
      int                    change_at;
      r = $urandom_range(0, 99);
      if (r < 84)      wdata = CFG_DATA_W'($urandom_range(1, 12));
      else if (r < 89) wdata = '0;
      else if (r < 93) wdata = CFG_DATA_W'($urandom_range(256, 511));
      else             wdata = CFG_DATA_W'($urandom_range(13, 255));
      write_register(REG_ROW_WIDTH, wdata);
      w = board.eff_width(wdata);
      write_register(REG_WINDOW_LENGTH, pick_window_data((w > 8) ? w : 8));
      grid_count = (w > 32) ? 1 : $urandom_range(1, 3);
      repeat (grid_count) begin
        calm_in = ($urandom_range(0, 3) == 0);
        if (w > 32) begin
          cells = $urandom_range(1, w + w / 2);
        end else begin
          rows  = $urandom_range(1, 8);
          cells = rows * w - $urandom_range(0, w - 1);
        end
        change_at = -1;
        if (cells > 1 && $urandom_range(0, 3) == 0) change_at = $urandom_range(1, cells - 1);
        run_grid(cells, ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(0, 20),
                 $urandom_range(0, 100), change_at);
        if ($urandom_range(0, 4) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (SETTLE * 2) @(posedge clk);
    if (board.mismatch_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/gwm_pkg.sv
hdl/gwm_channels_if.sv
hdl/gwm_line_scan.sv
hdl/gwm_col_mem.sv
hdl/grid_window_min_fill_scan.sv
tb/sv/testbench.sv
